### rtl/vsiq_pkg.sv
// Shared types and constants for the vehicle switch input qualifier.
`timescale 1ns / 1ps
`default_nettype none

package vsiq_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_WINDOW = 2'd0;
  localparam logic [1:0] CFG_ACC_ON      = 2'd1;
  localparam logic [1:0] CFG_ACC_OFF     = 2'd2;
  localparam logic [1:0] CFG_LEARN_LIMIT = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [15:0] INIT_WINDOW_RST = 16'd3000;
  localparam logic [7:0]  ACC_ON_RST      = 8'd10;
  localparam logic [7:0]  ACC_OFF_RST     = 8'd20;
  localparam logic [2:0]  LEARN_LIMIT_RST = 3'd3;

  // Ignition state reset value and cycle count ceiling
  localparam logic [7:0] ACC_LOW_RST   = 8'd20;
  localparam logic [2:0] CYCLE_MAX     = 3'd7;

  // Left turn debounce constants
  localparam logic [3:0] LEFT_ON_THRESH = 4'd4;
  localparam logic [3:0] LEFT_ON_HOLD   = 4'd9;
  localparam logic [2:0] LEFT_OFF_LATCH = 3'd4;
  localparam logic [2:0] LEFT_OFF_PLAIN = 3'd1;

  // Headlamp-dependent display settings
  localparam logic [3:0] LED_HEAD_ON   = 4'd5;
  localparam logic [3:0] LED_HEAD_OFF  = 4'd12;
  localparam logic [9:0] LOGO_HEAD_ON  = 10'd300;
  localparam logic [9:0] LOGO_HEAD_OFF = 10'd1000;
  localparam logic [9:0] LOGO_RST      = 10'd0;

  typedef struct packed {
    logic acc_level;
    logic left_turn_level;
    logic right_turn_level;
    logic side_lamp_level;
    logic head_lamp_level;
    logic run_active;
    logic link_ready;
  } in_item_t;

  typedef struct packed {
    logic       started;
    logic       learn_pulse;
    logic       learn_flag;
    logic       write_cancel;
    logic       left_lamp;
    logic       right_lamp;
    logic       side_lamp;
    logic       head_lamp;
    logic [3:0] display_level;
    logic [9:0] logo_value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] init_window_ticks;
    logic [7:0]  acc_on_ticks;
    logic [7:0]  acc_off_ticks;
    logic [2:0]  learn_cycle_limit;
  } cfg_t;

  typedef struct packed {
    logic started;
    logic learn_pulse;
    logic learn_flag;
    logic write_cancel;
  } acc_stat_t;

  typedef struct packed {
    logic       left_lamp;
    logic       right_lamp;
    logic       side_lamp;
    logic       head_lamp;
    logic [3:0] display_level;
    logic [9:0] logo_value;
  } lamp_stat_t;

endpackage

`default_nettype wire

### rtl/vehicle_switch_input_qualifier.sv
// A tick accepted into the input register moves on to the result register when the
// result register is free; otherwise it waits in the input register.
// Throughput: one tick per cycle while the output is not stalled; each register holds one beat.
// Reset (rst, synchronous, active high) empties both registers, resets all debounce state
// and loads the configuration defaults; the start-up window restarts from its length.
`timescale 1ns / 1ps
`default_nettype none

module vehicle_switch_input_qualifier (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire vsiq_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output vsiq_pkg::out_item_t                        out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [vsiq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [vsiq_pkg::CFG_DATA_W-1:0]       cfg_data
);

  vsiq_pkg::cfg_t       cfg;
  vsiq_pkg::in_item_t   in_hold;
  logic                 in_hold_valid;
  logic                 advance;
  logic                 timer_load;
  logic                 started_flag;
  vsiq_pkg::acc_stat_t  acc_stat;
  vsiq_pkg::lamp_stat_t lamp_stat;

  assign advance    = in_hold_valid && (!out_valid || !out_stall);
  assign in_stall   = in_hold_valid && !advance;
  assign timer_load = cfg_we && (cfg_index == vsiq_pkg::CFG_INIT_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_window_ticks <= vsiq_pkg::INIT_WINDOW_RST;
      cfg.acc_on_ticks      <= vsiq_pkg::ACC_ON_RST;
      cfg.acc_off_ticks     <= vsiq_pkg::ACC_OFF_RST;
      cfg.learn_cycle_limit <= vsiq_pkg::LEARN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsiq_pkg::CFG_INIT_WINDOW: cfg.init_window_ticks <= cfg_data;
        vsiq_pkg::CFG_ACC_ON:      cfg.acc_on_ticks      <= cfg_data[7:0];
        vsiq_pkg::CFG_ACC_OFF:     cfg.acc_off_ticks     <= cfg_data[7:0];
        vsiq_pkg::CFG_LEARN_LIMIT: cfg.learn_cycle_limit <= cfg_data[2:0];
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_hold_valid <= 1'b1;
    end else if (advance) begin
      in_hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_hold <= in_data;
    end
  end

  vsiq_acc u_acc (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .acc_level        (in_hold.acc_level),
    .cfg              (cfg),
    .timer_load       (timer_load),
    .timer_load_value (cfg_data),
    .started_flag     (started_flag),
    .stat_next        (acc_stat)
  );

  vsiq_lamp u_lamp (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (in_hold),
    .started_flag (started_flag),
    .stat_next    (lamp_stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.started       <= acc_stat.started;
      out_data.learn_pulse   <= acc_stat.learn_pulse;
      out_data.learn_flag    <= acc_stat.learn_flag;
      out_data.write_cancel  <= acc_stat.write_cancel;
      out_data.left_lamp     <= lamp_stat.left_lamp;
      out_data.right_lamp    <= lamp_stat.right_lamp;
      out_data.side_lamp     <= lamp_stat.side_lamp;
      out_data.head_lamp     <= lamp_stat.head_lamp;
      out_data.display_level <= lamp_stat.display_level;
      out_data.logo_value    <= lamp_stat.logo_value;
    end
  end

endmodule

`default_nettype wire

### rtl/vsiq_acc.sv
// Ignition debounce, started flag, cycle count and learn-mode request.
`timescale 1ns / 1ps
`default_nettype none

module vsiq_acc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               acc_level,
  input  wire vsiq_pkg::cfg_t     cfg,
  input  wire logic               timer_load,
  input  wire logic [15:0]        timer_load_value,
  output logic                    started_flag,
  output vsiq_pkg::acc_stat_t     stat_next
);

  logic [15:0] init_timer;
  logic [7:0]  acc_low_count;
  logic [7:0]  acc_high_count;
  logic        started_by_acc;
  logic [2:0]  acc_cycle_count;
  logic        learn_active;

  logic [15:0] init_timer_next;
  logic [7:0]  acc_low_count_next;
  logic [7:0]  acc_high_count_next;
  logic        started_flag_next;
  logic        started_by_acc_next;
  logic [2:0]  acc_cycle_count_next;
  logic        learn_active_next;
  logic        pulse;
  logic        cancel;
  logic [7:0]  high_inc;
  logic [8:0]  low_inc;

  always_comb begin
    init_timer_next      = (init_timer != 16'd0) ? init_timer - 16'd1 : init_timer;
    acc_low_count_next   = acc_low_count;
    acc_high_count_next  = acc_high_count;
    started_flag_next    = started_flag;
    started_by_acc_next  = started_by_acc;
    acc_cycle_count_next = acc_cycle_count;
    learn_active_next    = learn_active;
    pulse                = 1'b0;
    cancel               = 1'b0;
    high_inc             = acc_high_count + 8'd1;
    low_inc              = {1'b0, acc_low_count} + 9'd1;

    if (acc_level) begin
      acc_low_count_next = 8'd0;
      if (acc_high_count < cfg.acc_on_ticks) begin
        acc_high_count_next = high_inc;
        if (high_inc == cfg.acc_on_ticks) begin
          if (!started_flag) begin
            started_flag_next   = 1'b1;
            started_by_acc_next = 1'b1;
          end
          // Too many ignition cycles: clear the count, request learn in the window
          if (acc_cycle_count > cfg.learn_cycle_limit) begin
            acc_cycle_count_next = 3'd0;
            if (init_timer_next != 16'd0) begin
              pulse             = 1'b1;
              learn_active_next = 1'b1;
            end
          end
        end
      end
    end else begin
      if (low_inc > {1'b0, cfg.acc_off_ticks}) begin
        learn_active_next   = 1'b0;
        cancel              = 1'b1;
        acc_low_count_next  = 8'd0;
        acc_high_count_next = 8'd0;
        started_flag_next   = 1'b0;
        if (started_by_acc) begin
          if (acc_cycle_count != vsiq_pkg::CYCLE_MAX) begin
            acc_cycle_count_next = acc_cycle_count + 3'd1;
          end
          started_by_acc_next = 1'b0;
        end
      end else begin
        acc_low_count_next = low_inc[7:0];
      end
    end

    stat_next.started      = started_flag_next;
    stat_next.learn_pulse  = pulse;
    stat_next.learn_flag   = learn_active_next;
    stat_next.write_cancel = cancel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_timer      <= vsiq_pkg::INIT_WINDOW_RST;
      acc_low_count   <= vsiq_pkg::ACC_LOW_RST;
      acc_high_count  <= 8'd0;
      started_flag    <= 1'b0;
      started_by_acc  <= 1'b0;
      acc_cycle_count <= 3'd0;
      learn_active    <= 1'b0;
    end else if (timer_load) begin
      init_timer <= timer_load_value;
    end else if (step) begin
      init_timer      <= init_timer_next;
      acc_low_count   <= acc_low_count_next;
      acc_high_count  <= acc_high_count_next;
      started_flag    <= started_flag_next;
      started_by_acc  <= started_by_acc_next;
      acc_cycle_count <= acc_cycle_count_next;
      learn_active    <= learn_active_next;
    end
  end

endmodule

`default_nettype wire

### rtl/vsiq_lamp.sv
// Turn, side and headlamp switch debounce with lamp and display drive.
`timescale 1ns / 1ps
`default_nettype none

module vsiq_lamp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire vsiq_pkg::in_item_t  item,
  input  wire logic                started_flag,
  output vsiq_pkg::lamp_stat_t     stat_next
);

  logic [1:0] right_act, right_idle;
  logic [1:0] side_act, side_idle;
  logic [1:0] head_act, head_idle;
  logic [3:0] left_on_count;
  logic [2:0] left_off_count;
  logic       left_latched;
  logic       left_lamp, right_lamp, side_lamp, head_lamp;
  logic [3:0] brightness;
  logic [9:0] logo_setting;

  logic [1:0] right_act_next, right_idle_next;
  logic [1:0] side_act_next, side_idle_next;
  logic [1:0] head_act_next, head_idle_next;
  logic [3:0] left_on_count_next;
  logic [2:0] left_off_count_next;
  logic       left_latched_next;
  logic       left_lamp_next, right_lamp_next, side_lamp_next, head_lamp_next;
  logic [3:0] brightness_next;
  logic [9:0] logo_setting_next;
  logic [3:0] left_on_inc;
  logic [2:0] left_off_inc;
  logic [2:0] left_limit;

  // Saturating 0..3 step
  function automatic logic [1:0] sat3(input logic [1:0] c);
    sat3 = (c >= 2'd2) ? 2'd3 : c + 2'd1;
  endfunction

  always_comb begin
    right_act_next      = right_act;
    right_idle_next     = right_idle;
    side_act_next       = side_act;
    side_idle_next      = side_idle;
    head_act_next       = head_act;
    head_idle_next      = head_idle;
    left_on_count_next  = left_on_count;
    left_off_count_next = left_off_count;
    left_latched_next   = left_latched;
    left_lamp_next      = left_lamp;
    right_lamp_next     = right_lamp;
    side_lamp_next      = side_lamp;
    head_lamp_next      = head_lamp;
    brightness_next     = brightness;
    logo_setting_next   = logo_setting;
    left_on_inc         = left_on_count + 4'd1;
    left_off_inc        = left_off_count + 3'd1;
    left_limit          = left_latched ? vsiq_pkg::LEFT_OFF_LATCH : vsiq_pkg::LEFT_OFF_PLAIN;

    // Freeze the right turn, side and headlamp state while the link is not ready
    if (item.link_ready) begin
      if (!started_flag || !item.run_active) begin
        right_act_next = 2'd0;
        side_idle_next = 2'd0;
        head_idle_next = 2'd0;
      end else begin
        if (!item.right_turn_level) begin
          right_idle_next = 2'd0;
          if (right_act < 2'd2) begin
            right_act_next = right_act + 2'd1;
            if (right_act == 2'd1) begin
              right_lamp_next = 1'b1;
            end
          end
        end else begin
          if (right_idle >= 2'd1) begin
            right_idle_next = 2'd0;
            right_act_next  = 2'd0;
            right_lamp_next = 1'b0;
          end else begin
            right_idle_next = right_idle + 2'd1;
          end
        end

        if (!item.side_lamp_level) begin
          side_idle_next = 2'd0;
          side_act_next  = sat3(side_act);
          if (side_act >= 2'd2) begin
            side_lamp_next = 1'b1;
          end
        end else begin
          side_act_next  = 2'd0;
          side_idle_next = sat3(side_idle);
          if (side_idle >= 2'd2) begin
            side_lamp_next = 1'b0;
          end
        end

        if (!item.head_lamp_level) begin
          head_idle_next = 2'd0;
          head_act_next  = sat3(head_act);
          if (head_act >= 2'd2) begin
            head_lamp_next    = 1'b1;
            brightness_next   = vsiq_pkg::LED_HEAD_ON;
            logo_setting_next = vsiq_pkg::LOGO_HEAD_ON;
          end
        end else begin
          head_act_next  = 2'd0;
          head_idle_next = sat3(head_idle);
          if (head_idle >= 2'd2) begin
            head_lamp_next    = 1'b0;
            brightness_next   = vsiq_pkg::LED_HEAD_OFF;
            logo_setting_next = vsiq_pkg::LOGO_HEAD_OFF;
          end
        end
      end
    end

    if (item.run_active) begin
      if (!item.left_turn_level) begin
        left_off_count_next = 3'd0;
        if (left_on_inc > vsiq_pkg::LEFT_ON_THRESH) begin
          left_on_count_next = vsiq_pkg::LEFT_ON_HOLD;
          left_latched_next  = 1'b1;
          left_lamp_next     = 1'b1;
        end else begin
          left_on_count_next = left_on_inc;
        end
      end else begin
        // A latched lamp uses the longer release limit only on the first release tick, as the latch clears then
        left_on_count_next = 4'd0;
        left_latched_next  = 1'b0;
        if (left_off_inc > left_limit) begin
          left_off_count_next = left_limit + 3'd1;
          left_lamp_next      = 1'b0;
        end else begin
          left_off_count_next = left_off_inc;
        end
      end
    end

    stat_next.left_lamp     = left_lamp_next;
    stat_next.right_lamp    = right_lamp_next;
    stat_next.side_lamp     = side_lamp_next;
    stat_next.head_lamp     = head_lamp_next;
    stat_next.display_level = brightness_next;
    stat_next.logo_value    = logo_setting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_act      <= 2'd0;
      right_idle     <= 2'd0;
      side_act       <= 2'd0;
      side_idle      <= 2'd0;
      head_act       <= 2'd0;
      head_idle      <= 2'd0;
      left_on_count  <= 4'd0;
      left_off_count <= 3'd0;
      left_latched   <= 1'b0;
      left_lamp      <= 1'b0;
      right_lamp     <= 1'b0;
      side_lamp      <= 1'b0;
      head_lamp      <= 1'b0;
      brightness     <= vsiq_pkg::LED_HEAD_OFF;
      logo_setting   <= vsiq_pkg::LOGO_RST;
    end else if (step) begin
      right_act      <= right_act_next;
      right_idle     <= right_idle_next;
      side_act       <= side_act_next;
      side_idle      <= side_idle_next;
      head_act       <= head_act_next;
      head_idle      <= head_idle_next;
      left_on_count  <= left_on_count_next;
      left_off_count <= left_off_count_next;
      left_latched   <= left_latched_next;
      left_lamp      <= left_lamp_next;
      right_lamp     <= right_lamp_next;
      side_lamp      <= side_lamp_next;
      head_lamp      <= head_lamp_next;
      brightness     <= brightness_next;
      logo_setting   <= logo_setting_next;
    end
  end

endmodule

`default_nettype wire

### rtl/vsiq_checker.sv
// Port-level checks for the vehicle switch input qualifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module vsiq_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire vsiq_pkg::out_item_t                  out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A learn request only comes with the ignition started
  a_learn_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.learn_pulse |-> out_data.learn_flag && out_data.started)
    else $error("learn pulse without learn flag and started");

  // Ignition off drops started and learn mode
  a_cancel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_cancel |-> !out_data.started && !out_data.learn_flag)
    else $error("write cancel with started or learn flag set");

  // Display brightness follows the headlamp
  a_brightness: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.head_lamp ?
                   (out_data.display_level == vsiq_pkg::LED_HEAD_ON &&
                    out_data.logo_value == vsiq_pkg::LOGO_HEAD_ON) :
                   (out_data.display_level == vsiq_pkg::LED_HEAD_OFF)))
    else $error("brightness does not match headlamp");

endmodule

bind vehicle_switch_input_qualifier vsiq_checker u_vsiq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the vehicle switch input qualifier: random and directed ticks.
`timescale 1ns / 1ps

module testbench;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  vsiq_pkg::in_item_t               in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  vsiq_pkg::out_item_t              out_data;
  logic                             cfg_we    = 1'b0;
  logic [vsiq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [vsiq_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  vehicle_switch_input_qualifier dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("Test completed with failures");
    $finish;
  end

  vsiq_pkg::in_item_t  tick_queue[$];
  vsiq_pkg::out_item_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned learn_pulses = 0;
  int unsigned write_cancels = 0;
  int unsigned started_ticks = 0;
  int unsigned settings_run = 1;

  // Predicted configuration and qualifier state
  logic [15:0] window_left;
  logic [7:0]  on_ticks, off_ticks, ign_low, ign_high;
  logic [2:0]  cycle_limit, ign_cycles;
  logic        ign_started, ign_by_acc, learning;
  logic [3:0]  left_on;
  logic [2:0]  left_off;
  logic        left_hold;
  logic [1:0]  right_on, right_off, side_on, side_off, head_on, head_off;
  logic        lamp_left, lamp_right, lamp_side, lamp_head;
  logic [3:0]  led;
  logic [9:0]  logo;

  // Random switch pattern: level and remaining hold per input bit
  logic [6:0]  sw_level;
  int unsigned sw_hold[7];

  task automatic reset_model();
    on_ticks    = vsiq_pkg::ACC_ON_RST;
    off_ticks   = vsiq_pkg::ACC_OFF_RST;
    cycle_limit = vsiq_pkg::LEARN_LIMIT_RST;
    window_left = vsiq_pkg::INIT_WINDOW_RST;
    ign_low     = vsiq_pkg::ACC_LOW_RST;
    ign_high    = '0;
    ign_started = 1'b0;
    ign_by_acc  = 1'b0;
    ign_cycles  = '0;
    learning    = 1'b0;
    left_on     = '0;
    left_off    = '0;
    left_hold   = 1'b0;
    right_on    = '0;
    right_off   = '0;
    side_on     = '0;
    side_off    = '0;
    head_on     = '0;
    head_off    = '0;
    lamp_left   = 1'b0;
    lamp_right  = 1'b0;
    lamp_side   = 1'b0;
    lamp_head   = 1'b0;
    led         = vsiq_pkg::LED_HEAD_OFF;
    logo        = vsiq_pkg::LOGO_RST;
    sw_level    = 7'b1000000;
    foreach (sw_hold[i]) sw_hold[i] = 0;
  endtask

  function automatic vsiq_pkg::out_item_t qualify_tick(input vsiq_pkg::in_item_t t);
    vsiq_pkg::out_item_t r;
    int unsigned         low_next;
    logic                pulse;
    logic                cancel;
    logic [2:0]          left_limit;
    pulse  = 1'b0;
    cancel = 1'b0;
    if (window_left != 0) window_left--;

    // Right, side and head see the started flag from before this tick
    if (t.link_ready) begin
      if (!ign_started || !t.run_active) begin
        right_on = '0;
        side_off = '0;
        head_off = '0;
      end else begin
        if (!t.right_turn_level) begin
          right_off = '0;
          if (right_on < 2) begin
            right_on++;
            if (right_on == 2) lamp_right = 1'b1;
          end
        end else begin
          right_off++;
          if (right_off > 1) begin
            right_off  = '0;
            right_on   = '0;
            lamp_right = 1'b0;
          end
        end
        if (!t.side_lamp_level) begin
          side_off = '0;
          if (side_on >= 2) begin
            side_on   = 2'd3;
            lamp_side = 1'b1;
          end else side_on++;
        end else begin
          side_on = '0;
          if (side_off >= 2) begin
            side_off  = 2'd3;
            lamp_side = 1'b0;
          end else side_off++;
        end
        if (!t.head_lamp_level) begin
          head_off = '0;
          if (head_on >= 2) begin
            head_on   = 2'd3;
            lamp_head = 1'b1;
            led       = vsiq_pkg::LED_HEAD_ON;
            logo      = vsiq_pkg::LOGO_HEAD_ON;
          end else head_on++;
        end else begin
          head_on = '0;
          if (head_off >= 2) begin
            head_off  = 2'd3;
            lamp_head = 1'b0;
            led       = vsiq_pkg::LED_HEAD_OFF;
            logo      = vsiq_pkg::LOGO_HEAD_OFF;
          end else head_off++;
        end
      end
    end

    if (t.acc_level) begin
      ign_low = '0;
      if (ign_high < on_ticks) begin
        ign_high++;
        if (ign_high == on_ticks) begin
          if (!ign_started) begin
            ign_started = 1'b1;
            ign_by_acc  = 1'b1;
          end
          if (ign_cycles > cycle_limit) begin
            ign_cycles = '0;
            if (window_left != 0) begin
              pulse    = 1'b1;
              learning = 1'b1;
            end
          end
        end
      end
    end else begin
      // compare before storing so a threshold of 255 needs 256 low ticks
      low_next = ign_low + 1;
      if (low_next > off_ticks) begin
        learning    = 1'b0;
        cancel      = 1'b1;
        ign_low     = '0;
        ign_high    = '0;
        ign_started = 1'b0;
        if (ign_by_acc) begin
          if (ign_cycles < vsiq_pkg::CYCLE_MAX) ign_cycles++;
          ign_by_acc = 1'b0;
        end
      end else ign_low = low_next[7:0];
    end

    if (t.run_active) begin
      if (!t.left_turn_level) begin
        left_off = '0;
        left_on++;
        if (left_on > vsiq_pkg::LEFT_ON_THRESH) begin
          left_on   = vsiq_pkg::LEFT_ON_HOLD;
          left_hold = 1'b1;
          lamp_left = 1'b1;
        end
      end else begin
        left_on = '0;
        left_off++;
        left_limit = left_hold ? vsiq_pkg::LEFT_OFF_LATCH : vsiq_pkg::LEFT_OFF_PLAIN;
        left_hold  = 1'b0;
        if (left_off > left_limit) begin
          left_off  = left_limit + 3'd1;
          lamp_left = 1'b0;
        end
      end
    end

    r.started       = ign_started;
    r.learn_pulse   = pulse;
    r.learn_flag    = learning;
    r.write_cancel  = cancel;
    r.left_lamp     = lamp_left;
    r.right_lamp    = lamp_right;
    r.side_lamp     = lamp_side;
    r.head_lamp     = lamp_head;
    r.display_level = led;
    r.logo_value    = logo;
    return r;
  endfunction

  task automatic check_result(input vsiq_pkg::out_item_t got, input vsiq_pkg::out_item_t want);
    if (got.started !== want.started) begin
      $error("started: expected %0d, got %0d", want.started, got.started);
      fail_count++;
    end
    if (got.learn_pulse !== want.learn_pulse) begin
      $error("learn_pulse: expected %0d, got %0d", want.learn_pulse, got.learn_pulse);
      fail_count++;
    end
    if (got.learn_flag !== want.learn_flag) begin
      $error("learn_flag: expected %0d, got %0d", want.learn_flag, got.learn_flag);
      fail_count++;
    end
    if (got.write_cancel !== want.write_cancel) begin
      $error("write_cancel: expected %0d, got %0d", want.write_cancel, got.write_cancel);
      fail_count++;
    end
    if (got.left_lamp !== want.left_lamp) begin
      $error("left_lamp: expected %0d, got %0d", want.left_lamp, got.left_lamp);
      fail_count++;
    end
    if (got.right_lamp !== want.right_lamp) begin
      $error("right_lamp: expected %0d, got %0d", want.right_lamp, got.right_lamp);
      fail_count++;
    end
    if (got.side_lamp !== want.side_lamp) begin
      $error("side_lamp: expected %0d, got %0d", want.side_lamp, got.side_lamp);
      fail_count++;
    end
    if (got.head_lamp !== want.head_lamp) begin
      $error("head_lamp: expected %0d, got %0d", want.head_lamp, got.head_lamp);
      fail_count++;
    end
    if (got.display_level !== want.display_level) begin
      $error("display_level: expected %0d, got %0d", want.display_level, got.display_level);
      fail_count++;
    end
    if (got.logo_value !== want.logo_value) begin
      $error("logo_value: expected %0d, got %0d", want.logo_value, got.logo_value);
      fail_count++;
    end
  endtask

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Ignition hold lengths cluster round the thresholds so that full cycles happen
  function automatic int unsigned hold_length(input int s, input logic lvl);
    int unsigned r;
    int unsigned hold;
    r = $urandom_range(0, 99);
    if (s == 6) begin
      if (r < 12) hold = $urandom_range(1, 3);
      else if (r < 22) hold = lvl ? on_ticks : off_ticks;
      else if (r < 30 && !lvl) hold = 2 * off_ticks + 3;
      else hold = (lvl ? on_ticks : off_ticks + 1) + $urandom_range(0, 6);
    end else if (s <= 1) begin
      hold = lvl ? $urandom_range(20, 150) : $urandom_range(1, 6);
    end else begin
      hold = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 30);
    end
    if (hold == 0) hold = 1;
    return hold;
  endfunction

  task automatic queue_ticks(input int n, input vsiq_pkg::in_item_t t);
    repeat (n) tick_queue.push_back(t);
  endtask

  task automatic queue_random_ticks(input int n);
    logic [6:0] bits;
    int         k;
    repeat (n) begin
      for (int s = 0; s < 7; s++) begin
        if (sw_hold[s] == 0) begin
          sw_level[s] = ~sw_level[s];
          sw_hold[s]  = hold_length(s, sw_level[s]);
        end
        sw_hold[s]--;
      end
      bits = sw_level;
      // one-tick glitch on a switch, run or link line
      if ($urandom_range(0, 39) == 0) begin
        k       = $urandom_range(0, 5);
        bits[k] = ~bits[k];
      end
      tick_queue.push_back(vsiq_pkg::in_item_t'(bits));
    end
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [vsiq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [vsiq_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vsiq_pkg::CFG_INIT_WINDOW: window_left = val;
      vsiq_pkg::CFG_ACC_ON:      on_ticks    = val[7:0];
      vsiq_pkg::CFG_ACC_OFF:     off_ticks   = val[7:0];
      vsiq_pkg::CFG_LEARN_LIMIT: cycle_limit = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned window, input int unsigned on,
                            input int unsigned off, input int unsigned limit);
    write_reg(vsiq_pkg::CFG_INIT_WINDOW, 16'(window));
    write_reg(vsiq_pkg::CFG_ACC_ON, 16'(on));
    write_reg(vsiq_pkg::CFG_ACC_OFF, 16'(off));
    write_reg(vsiq_pkg::CFG_LEARN_LIMIT, 16'(limit));
    settings_run++;
  endtask

  // Sender: one beat per pop, random gaps, calm stretches with no gaps
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(qualify_tick(in_data));
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= tick_queue.pop_front();
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = idle_length();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(16, 64);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted beat, stall at random
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat %h arrived with no tick pending", out_data);
        fail_count++;
      end else begin
        check_result(out_data, expected_results.pop_front());
      end
      if (out_data.learn_pulse) learn_pulses++;
      if (out_data.write_cancel) write_cancels++;
      if (out_data.started) started_ticks++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (stall_calm > 0) begin
        stall_calm--;
      end else begin
        stall_left = idle_length();
        if ($urandom_range(0, 39) == 0) stall_calm = $urandom_range(16, 64);
      end
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Bit order: acc, left, right, side, head, run, link; lamp switches active low
    queue_ticks(1, 7'b0000000);
    queue_ticks(1, 7'b1111111);
    drain();
    set_config(100, 2, 1, 0);
    queue_ticks(2, 7'b1000011);   // start with every lamp switch active
    queue_ticks(3, 7'b0000011);   // stop, cycle counted
    queue_ticks(2, 7'b1000011);   // restart past the limit: learn pulse
    queue_ticks(4, 7'b1111111);   // release all switches
    queue_ticks(2, 7'b0000011);   // stop clears learn
    queue_ticks(6, 7'b1011110);   // left turn held long enough to latch, link down
    queue_ticks(3, 7'b1111110);
    drain();

    set_config(vsiq_pkg::INIT_WINDOW_RST, vsiq_pkg::ACC_ON_RST, vsiq_pkg::ACC_OFF_RST,
               vsiq_pkg::LEARN_LIMIT_RST);
    queue_random_ticks(350);
    drain();

    set_config(16'hFFFF, 1, 1, 0);
    queue_random_ticks(350);
    drain();

    set_config(0, 255, 255, 7);
    queue_random_ticks(500);
    drain();

    set_config($urandom_range(50, 400), $urandom_range(2, 20),
               $urandom_range(2, 30), $urandom_range(1, 3));
    queue_random_ticks(300);
    drain();

    set_config($urandom_range(0, 65535), $urandom_range(1, 40),
               $urandom_range(1, 40), $urandom_range(0, 7));
    queue_random_ticks(250);
    drain();

    repeat (8) @(posedge clk);
    $display("Ran %0d ticks over %0d register settings, %0d of them with ignition started.",
             ticks_sent, settings_run, started_ticks);
    $display("Saw %0d learn pulses and %0d write cancels.", learn_pulses, write_cancels);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### vehicle_switch_input_qualifier.f
rtl/vsiq_pkg.sv
rtl/vsiq_acc.sv
rtl/vsiq_lamp.sv
rtl/vehicle_switch_input_qualifier.sv
rtl/vsiq_checker.sv
verif/testbench.sv
